// File: hw/rtl/prs_pkg.sv
package prs_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 5;
  localparam int MAX_NAKS = 63;
  localparam int NAK_W    = 6;
  localparam int ID_W     = 32;
  localparam int LEN_W    = 16;
  localparam int TMO_W    = 8;
  localparam int KIND_W   = 3;
  localparam int CODE_W   = 3;
  localparam int ALU_W    = 33;
  localparam int ADDR_W   = 2;
  localparam int PDATA_W  = 32;

  localparam logic [ID_W-1:0]   FIRST_ID      = 32'd2;
  localparam logic [TMO_W-1:0]  RESET_TIMEOUT = 8'd20;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT  = 2'd0;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_NAK     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_ACK     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_STALE   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_FULL    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_POPPED  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_EMPTY   = 3'd5;
  localparam logic [CODE_W-1:0] CODE_DONE    = 3'd6;
  localparam logic [CODE_W-1:0] CODE_TIMEOUT = 3'd7;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] sum;
  } alu_rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              timed_out;
    logic              last;
  } result_t;

endpackage

// File: hw/rtl/packet_receive_sequencer.sv
// Receive-side sequencer of a packet link.
// Input channel (in_*): one item per command. in_tuser carries the kind
// (clear, store, get, release, timeout query); in_tdata carries the packet id,
// length, slot handed back and current time. in_tready is high only while the
// sequencer is idle, so one item is worked on at a time.
// Result channel (out_*): one or more items per input item; out_tlast marks
// the final one. out_tuser carries the result code.
// Steps from accept to the first result: clear, release and unknown kinds
// answer from decode; timeout query: decode, compare; get: decode, length
// read, output; store: decode, check, then for a packet neither stale nor
// refused one NAK per skipped id (at most 63) and the ACK. The next item is
// taken the cycle after the last result is loaded. All id arithmetic, the stale
// check and the timeout compare go through one shared 33-bit add/subtract unit.
// Reset: expected id 2, queue empty, all 16 slots free, timeout limit 20 s.
// A stalled receiver (out_tready low) holds the result register; the
// sequencer waits in place until it drains.
// Configuration: APB register 0 at address 0 holds the timeout limit.
module packet_receive_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,  // seq_id[31:0] byte_count[47:32] slot_in[51:48] now_seconds[83:52]
  input  logic [2:0]   in_tuser,  // kind[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata, // id_out[31:0] slot_out[35:32] length_out[51:36] timed_out[52]
  output logic [2:0]   out_tuser, // code[2:0]
  output logic         out_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] S_DECODE  = 3'd1;
  localparam logic [ST_W-1:0] S_CHECK   = 3'd2;
  localparam logic [ST_W-1:0] S_NAK     = 3'd3;
  localparam logic [ST_W-1:0] S_ACK     = 3'd4;
  localparam logic [ST_W-1:0] S_GET_LEN = 3'd5;
  localparam logic [ST_W-1:0] S_GET_OUT = 3'd6;
  localparam logic [ST_W-1:0] S_TMO     = 3'd7;

  logic [ST_W-1:0] state_r, state_nxt;

  // latched input item
  logic [prs_pkg::KIND_W-1:0] kind_r;
  logic [prs_pkg::ID_W-1:0]   seq_r;
  logic [prs_pkg::LEN_W-1:0]  len_r;
  logic [prs_pkg::SLOT_W-1:0] slot_in_r;
  logic [prs_pkg::ID_W-1:0]   now_r;

  // link state
  logic [prs_pkg::TMO_W-1:0]  tmo_r;
  logic [prs_pkg::ID_W-1:0]   exp_r, exp_nxt;
  logic [prs_pkg::ID_W-1:0]   arr_r, arr_nxt;
  logic [prs_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic [prs_pkg::CNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [prs_pkg::CNT_W-1:0]  free_cnt_r, free_cnt_nxt;

  logic [prs_pkg::SLOT_W-1:0] free_stack_r [prs_pkg::SLOTS];
  logic [prs_pkg::SLOT_W-1:0] order_fifo_r [prs_pkg::SLOTS];
  logic [prs_pkg::LEN_W-1:0]  slot_len_r   [prs_pkg::SLOTS];

  // working registers
  logic [prs_pkg::ALU_W-1:0]  sum_r, sum_nxt;
  logic                       carry_r, carry_nxt;
  logic [prs_pkg::NAK_W-1:0]  nak_left_r, nak_left_nxt;
  logic [prs_pkg::ID_W-1:0]   nak_id_r, nak_id_nxt;
  logic [prs_pkg::SLOT_W-1:0] pop_slot_r;
  logic [prs_pkg::LEN_W-1:0]  pop_len_r;

  // output register
  logic                       out_valid_r;
  prs_pkg::result_t           out_r;

  prs_pkg::alu_req_t alu_req;
  prs_pkg::alu_rsp_t alu_rsp;

  logic                       out_free;
  logic                       emit;
  prs_pkg::result_t           emit_res;
  logic                       free_all;
  logic                       push_free;
  logic                       take_slot;
  logic                       pop_rd;
  logic [prs_pkg::CNT_W-1:0]  free_cnt_m1;
  logic [prs_pkg::SLOT_W-1:0] top_idx;
  logic [prs_pkg::SLOT_W-1:0] tail_idx;
  logic [prs_pkg::SLOT_W-1:0] ack_slot;
  logic [prs_pkg::ID_W-1:0]   gap;
  logic [prs_pkg::NAK_W-1:0]  nak_cnt;
  logic                       cfg_wr;

  prs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.code;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'd0, out_r.timed_out, out_r.len, out_r.slot, out_r.id};

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == prs_pkg::ADDR_TIMEOUT);
  assign prdata = (paddr == prs_pkg::ADDR_TIMEOUT) ?
                  {{(prs_pkg::PDATA_W - prs_pkg::TMO_W){1'b0}}, tmo_r} : '0;

  // top of free stack and tail of the arrival queue
  assign free_cnt_m1 = free_cnt_r - 1'b1;
  assign top_idx     = free_cnt_m1[prs_pkg::SLOT_W-1:0];
  assign ack_slot    = free_stack_r[top_idx];
  assign tail_idx    = head_r + fcnt_r[prs_pkg::SLOT_W-1:0];

  // gap below the packet id, capped for the NAK burst
  assign gap     = sum_r[prs_pkg::ID_W-1:0];
  assign nak_cnt = (gap > prs_pkg::ID_W'(prs_pkg::MAX_NAKS)) ?
                   prs_pkg::NAK_W'(prs_pkg::MAX_NAKS) : gap[prs_pkg::NAK_W-1:0];

  // operand select for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_DECODE: begin
        if (kind_r == prs_pkg::KIND_TIMEOUT) begin
          alu_req.a = {1'b0, arr_r};
          alu_req.b = {{(prs_pkg::ALU_W - prs_pkg::TMO_W){1'b0}}, tmo_r};
        end else begin
          // seq - expected: carry clear means stale
          alu_req.a   = {1'b0, seq_r};
          alu_req.b   = {1'b0, exp_r};
          alu_req.sub = 1'b1;
        end
      end
      S_NAK: begin
        alu_req.a = {1'b0, nak_id_r};
        alu_req.b = prs_pkg::ALU_W'(1);
      end
      S_ACK: begin
        alu_req.a = {1'b0, seq_r};
        alu_req.b = prs_pkg::ALU_W'(1);
      end
      S_TMO: begin
        // deadline (arrival + limit) - now: carry clear means deadline below now
        alu_req.a   = sum_r;
        alu_req.b   = {1'b0, now_r};
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    exp_nxt      = exp_r;
    arr_nxt      = arr_r;
    head_nxt     = head_r;
    fcnt_nxt     = fcnt_r;
    free_cnt_nxt = free_cnt_r;
    sum_nxt      = sum_r;
    carry_nxt    = carry_r;
    nak_left_nxt = nak_left_r;
    nak_id_nxt   = nak_id_r;
    emit         = 1'b0;
    emit_res     = '0;
    free_all     = 1'b0;
    push_free    = 1'b0;
    take_slot    = 1'b0;
    pop_rd       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (kind_r)
          prs_pkg::KIND_CLEAR: begin
            if (out_free) begin
              head_nxt      = '0;
              fcnt_nxt      = '0;
              exp_nxt       = prs_pkg::FIRST_ID;
              arr_nxt       = now_r;
              free_all      = 1'b1;
              free_cnt_nxt  = prs_pkg::CNT_W'(prs_pkg::SLOTS);
              emit          = 1'b1;
              emit_res.code = prs_pkg::CODE_DONE;
              emit_res.last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          prs_pkg::KIND_STORE: begin
            // every store, also a dropped one, stamps the arrival time
            arr_nxt   = now_r;
            sum_nxt   = alu_rsp.sum;
            carry_nxt = alu_rsp.carry;
            state_nxt = S_CHECK;
          end
          prs_pkg::KIND_GET: begin
            if (fcnt_r == '0) begin
              if (out_free) begin
                emit          = 1'b1;
                emit_res.code = prs_pkg::CODE_EMPTY;
                emit_res.last = 1'b1;
                state_nxt     = S_IDLE;
              end
            end else begin
              pop_rd    = 1'b1;
              head_nxt  = head_r + 1'b1;
              fcnt_nxt  = fcnt_r - 1'b1;
              state_nxt = S_GET_LEN;
            end
          end
          prs_pkg::KIND_RELEASE: begin
            if (out_free) begin
              if (free_cnt_r < prs_pkg::CNT_W'(prs_pkg::SLOTS)) begin
                push_free    = 1'b1;
                free_cnt_nxt = free_cnt_r + 1'b1;
              end
              emit          = 1'b1;
              emit_res.code = prs_pkg::CODE_DONE;
              emit_res.last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          prs_pkg::KIND_TIMEOUT: begin
            sum_nxt   = alu_rsp.sum;
            state_nxt = S_TMO;
          end
          default: begin
            if (out_free) begin
              emit          = 1'b1;
              emit_res.code = prs_pkg::CODE_DONE;
              emit_res.last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      S_CHECK: begin
        if (out_free) begin
          if (!carry_r) begin
            emit          = 1'b1;
            emit_res.code = prs_pkg::CODE_STALE;
            emit_res.id   = seq_r;
            emit_res.last = 1'b1;
            state_nxt     = S_IDLE;
          end else if (free_cnt_r == '0 ||
                       fcnt_r == prs_pkg::CNT_W'(prs_pkg::SLOTS)) begin
            emit          = 1'b1;
            emit_res.code = prs_pkg::CODE_FULL;
            emit_res.id   = seq_r;
            emit_res.last = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            nak_left_nxt = nak_cnt;
            nak_id_nxt   = exp_r;
            state_nxt    = (nak_cnt == '0) ? S_ACK : S_NAK;
          end
        end
      end
      S_NAK: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.code = prs_pkg::CODE_NAK;
          emit_res.id   = nak_id_r;
          nak_id_nxt    = alu_rsp.sum[prs_pkg::ID_W-1:0];
          nak_left_nxt  = nak_left_r - 1'b1;
          if (nak_left_r == prs_pkg::NAK_W'(1)) state_nxt = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          exp_nxt       = alu_rsp.sum[prs_pkg::ID_W-1:0];
          free_cnt_nxt  = free_cnt_m1;
          fcnt_nxt      = fcnt_r + 1'b1;
          take_slot     = 1'b1;
          emit          = 1'b1;
          emit_res.code = prs_pkg::CODE_ACK;
          emit_res.id   = seq_r;
          emit_res.slot = ack_slot;
          emit_res.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GET_LEN: begin
        state_nxt = S_GET_OUT;
      end
      S_GET_OUT: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.code = prs_pkg::CODE_POPPED;
          emit_res.slot = pop_slot_r;
          emit_res.len  = pop_len_r;
          emit_res.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TMO: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_res.code      = prs_pkg::CODE_TIMEOUT;
          emit_res.timed_out = !alu_rsp.carry;
          emit_res.last      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tmo_r       <= prs_pkg::RESET_TIMEOUT;
      exp_r       <= prs_pkg::FIRST_ID;
      arr_r       <= '0;
      head_r      <= '0;
      fcnt_r      <= '0;
      free_cnt_r  <= prs_pkg::CNT_W'(prs_pkg::SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      exp_r      <= exp_nxt;
      arr_r      <= arr_nxt;
      head_r     <= head_nxt;
      fcnt_r     <= fcnt_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (cfg_wr) tmo_r <= pwdata[prs_pkg::TMO_W-1:0];
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // free stack: reset and clear restore every slot number
  always_ff @(posedge clk) begin
    if (!rst_n || free_all) begin
      for (int i = 0; i < prs_pkg::SLOTS; i++) begin
        free_stack_r[i] <= prs_pkg::SLOT_W'(i);
      end
    end else if (push_free) begin
      free_stack_r[free_cnt_r[prs_pkg::SLOT_W-1:0]] <= slot_in_r;
    end
  end

  // payload registers and queue storage
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r    <= in_tuser;
      seq_r     <= in_tdata[31:0];
      len_r     <= in_tdata[47:32];
      slot_in_r <= in_tdata[51:48];
      now_r     <= in_tdata[83:52];
    end
    sum_r      <= sum_nxt;
    carry_r    <= carry_nxt;
    nak_left_r <= nak_left_nxt;
    nak_id_r   <= nak_id_nxt;
    if (emit) out_r <= emit_res;
    if (take_slot) begin
      order_fifo_r[tail_idx] <= ack_slot;
      slot_len_r[ack_slot]   <= len_r;
    end
    if (pop_rd) pop_slot_r <= order_fifo_r[head_r];
    pop_len_r <= slot_len_r[pop_slot_r];
  end

endmodule

// File: hw/rtl/prs_alu.sv
module prs_alu (
  input  prs_pkg::alu_req_t req,
  output prs_pkg::alu_rsp_t rsp
);

  // a + b, or a - b with carry set when a >= b
  always_comb begin
    logic [prs_pkg::ALU_W:0] full;
    full = {1'b0, req.a}
         + {1'b0, (req.sub ? ~req.b : req.b)}
         + (prs_pkg::ALU_W + 1)'(req.sub);
    rsp.sum   = full[prs_pkg::ALU_W-1:0];
    rsp.carry = full[prs_pkg::ALU_W];
  end

endmodule

// File: hw/rtl/prs_checker.sv
module prs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // one item at a time: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // timeout register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr == 2'd0) ##1 (paddr == 2'd0) |->
      prdata == {24'd0, $past(pwdata[7:0])})
    else $error("timeout register readback mismatch");

endmodule

bind packet_receive_sequencer prs_checker u_prs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

// File: bench/tb_packet_receive_sequencer.sv
`timescale 1ns / 100ps

module tb_packet_receive_sequencer;
  import prs_pkg::*;

  // Item kinds the sequencer treats as unknown: it answers each with a bare "done".
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;

  // Allow for 64 replies each behind a full receiver stall, plus sender gaps.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [87:0]        in_tdata = '0;   // seq_id, byte_count, slot_in, now_seconds, pad
  logic [KIND_W-1:0]  in_tuser = '0;   // kind
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [55:0]        out_tdata;       // id_out, slot_out, length_out, timed_out, pad
  logic [CODE_W-1:0]  out_tuser;       // code
  logic               out_tlast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow of the sequencer state, advanced as each item is accepted.
  logic [TMO_W-1:0]  tmo_limit;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   arrival_secs;
  logic [SLOT_W-1:0] order_q [SLOTS];
  logic [LEN_W-1:0]  slot_len [SLOTS];
  logic [SLOT_W-1:0] free_stack [SLOTS];
  logic [SLOT_W-1:0] q_head;
  logic [CNT_W-1:0]  q_count;
  logic [CNT_W-1:0]  free_count;

  result_t           owed_replies[$];  // replies the sequencer still owes, oldest first
  logic [SLOT_W-1:0] held_slots[$];    // slots popped by a get and not yet handed back

  logic        gaps_on = 1'b1;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          replies_seen = 0;
  int          naks_seen = 0;
  int          refusals_seen = 0;
  logic [ID_W-1:0]  wall_secs = 32'd50;
  logic [TMO_W-1:0] last_limit;

  packet_receive_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model of the sequencer
  // ---------------------------------------------------------------------------

  function automatic void owe_reply(logic [CODE_W-1:0] code, logic [ID_W-1:0] id,
                                    logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len,
                                    logic timed_out, logic last);
    result_t r;
    r.code      = code;
    r.id        = id;
    r.slot      = slot;
    r.len       = len;
    r.timed_out = timed_out;
    r.last      = last;
    owed_replies.push_back(r);
  endfunction

  function automatic void free_every_slot();
    for (int i = 0; i < SLOTS; i++) free_stack[i] = SLOT_W'(i);
    free_count = CNT_W'(SLOTS);
  endfunction

  // Advance the shadow state by one accepted item and queue the replies it causes.
  task automatic model_sequencer(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] seq,
                                 input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] slot,
                                 input logic [ID_W-1:0] now);
    logic [ID_W-1:0]   gap;
    int                naks;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] tail;
    logic [ALU_W-1:0]  deadline;
    case (kind)
      KIND_CLEAR: begin
        q_head       = '0;
        q_count      = '0;
        next_id      = FIRST_ID;
        arrival_secs = now;
        free_every_slot();
        held_slots.delete();
        owe_reply(CODE_DONE, '0, '0, '0, 1'b0, 1'b1);
      end
      KIND_STORE: begin
        // Every store stamps the arrival time, dropped or refused ones too.
        arrival_secs = now;
        if (seq < next_id) begin
          owe_reply(CODE_STALE, seq, '0, '0, 1'b0, 1'b1);
        end else if (free_count == 0 || q_count >= SLOTS) begin
          owe_reply(CODE_FULL, seq, '0, '0, 1'b0, 1'b1);
        end else begin
          // NAK the lowest skipped ids only, but jump the expected id past the whole gap.
          gap  = seq - next_id;
          naks = (gap > MAX_NAKS) ? MAX_NAKS : int'(gap);
          for (int i = 0; i < naks; i++)
            owe_reply(CODE_NAK, next_id + ID_W'(i), '0, '0, 1'b0, 1'b0);
          next_id        = seq + 1'b1;
          free_count     = free_count - 1'b1;
          s              = free_stack[free_count[SLOT_W-1:0]];
          slot_len[s]    = len;
          tail           = q_head + q_count[SLOT_W-1:0];
          order_q[tail]  = s;
          q_count        = q_count + 1'b1;
          owe_reply(CODE_ACK, seq, s, '0, 1'b0, 1'b1);
        end
      end
      KIND_GET: begin
        if (q_count == 0) begin
          owe_reply(CODE_EMPTY, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          s       = order_q[q_head];
          q_head  = q_head + 1'b1;
          q_count = q_count - 1'b1;
          held_slots.push_back(s);
          owe_reply(CODE_POPPED, '0, s, slot_len[s], 1'b0, 1'b1);
        end
      end
      KIND_RELEASE: begin
        // A release onto a full free stack is dropped silently.
        if (free_count < SLOTS) begin
          free_stack[free_count[SLOT_W-1:0]] = slot;
          free_count = free_count + 1'b1;
        end
        owe_reply(CODE_DONE, '0, '0, '0, 1'b0, 1'b1);
      end
      KIND_TIMEOUT: begin
        // Form the deadline in 33 bits so it never wraps.
        deadline = {1'b0, arrival_secs} + ALU_W'(tmo_limit);
        owe_reply(CODE_TIMEOUT, '0, '0, '0, deadline < {1'b0, now}, 1'b1);
      end
      default: owe_reply(CODE_DONE, '0, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item, hold it until the sequencer takes it, then update the shadow.
  // Leave tvalid high afterwards so back-to-back items never toggle it in one step.
  task automatic issue_command(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] seq,
                               input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] slot,
                               input logic [ID_W-1:0] now);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, now, slot, len, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    model_sequencer(kind, seq, len, slot, now);
  endtask

  // Drop tvalid and hold off until every owed reply has come back.
  task automatic wait_replies_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (owed_replies.size() != 0);
  endtask

  // APB write of the timeout limit: setup cycle, then access until pready.
  task automatic write_timeout_limit(input logic [TMO_W-1:0] secs);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= PDATA_W'(secs);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    tmo_limit  = secs;
    last_limit = secs;
  endtask

  // Receiver back-pressure: random stall bursts while gaps are on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Reply checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (out_tuser == CODE_NAK) naks_seen++;
      if (out_tuser == CODE_FULL) refusals_seen++;
      if (owed_replies.size() == 0) begin
        $error("reply with nothing owed: code %0d id %0h", out_tuser, out_tdata[31:0]);
        mismatch_count++;
      end else begin
        want = owed_replies.pop_front();
        compare_field("code",       ID_W'(want.code),      ID_W'(out_tuser));
        compare_field("id_out",     want.id,               out_tdata[31:0]);
        compare_field("slot_out",   ID_W'(want.slot),      ID_W'(out_tdata[35:32]));
        compare_field("length_out", ID_W'(want.len),       ID_W'(out_tdata[51:36]));
        compare_field("timed_out",  ID_W'(want.timed_out), ID_W'(out_tdata[52]));
        compare_field("last",       ID_W'(want.last),      ID_W'(out_tlast));
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d replies owed",
               idle_cycles, owed_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty get, release onto a full free stack, clear, a stale id, and the
  // timeout compare on both sides of the default limit.
  task automatic test_idle_corners();
    issue_command(KIND_GET,     32'd0, 16'd0, 4'd0, 32'd0);
    issue_command(KIND_RELEASE, 32'd0, 16'd0, 4'd9, 32'd0);
    issue_command(KIND_CLEAR,   32'd0, 16'd0, 4'd0, 32'd7);
    issue_command(KIND_STORE,   32'd1, 16'd3, 4'd0, 32'd10);
    issue_command(KIND_TIMEOUT, 32'd0, 16'd0, 4'd0, 32'd30);
    issue_command(KIND_TIMEOUT, 32'd0, 16'd0, 4'd0, 32'd31);
  endtask

  // In-order ack, a short gap, a gap past the NAK cap, and the id wrapping to zero.
  task automatic test_nak_and_wrap();
    issue_command(KIND_STORE, 32'd2,          16'hFFFF, 4'hF, 32'd40);
    issue_command(KIND_STORE, 32'd5,          16'h0000, 4'h0, 32'd41);
    issue_command(KIND_STORE, 32'hFFFF_FFF0,  16'h1234, 4'h0, 32'd42);
    issue_command(KIND_STORE, 32'hFFFF_FFFF,  16'hA5A5, 4'h0, 32'd43);
    issue_command(KIND_STORE, 32'h0000_0000,  16'h5A5A, 4'h0, 32'd44);
  endtask

  // Fill every slot, refuse on an empty free stack, then on a full queue with a
  // slot freed, and check the deadline sum does not wrap near the top of time.
  task automatic test_full_queue();
    while (q_count < SLOTS)
      issue_command(KIND_STORE, next_id, 16'($urandom()), 4'h0, wall_secs);
    issue_command(KIND_STORE,   next_id, 16'd77, 4'h0, wall_secs);
    issue_command(KIND_RELEASE, 32'd0,   16'd0,  4'd3, 32'd0);
    issue_command(KIND_STORE,   next_id, 16'd88, 4'h0, 32'hFFFF_FFFF);
    issue_command(KIND_TIMEOUT, 32'd0,   16'd0,  4'h0, 32'hFFFF_FFFF);
  endtask

  // Mostly well-formed traffic: in-order stores, gets, releases of popped slots and
  // timeout queries, salted with gaps, stale ids, stray releases, clears and unknown kinds.
  task automatic run_mixed_traffic(input int n_items, input int pause_at);
    int               k;
    int               r;
    int               pick;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   seq;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   now;
    for (k = 0; k < n_items; k++) begin
      r    = $urandom_range(0, 99);
      seq  = $urandom();
      len  = 16'($urandom());
      slot = 4'($urandom_range(0, 15));
      now  = $urandom();
      wall_secs = wall_secs + ID_W'($urandom_range(0, 40));
      if ($urandom_range(0, 30) == 0) wall_secs = $urandom();
      if (r < 36) begin
        kind = KIND_STORE;
        now  = wall_secs;
        pick = $urandom_range(0, 99);
        if (pick < 66)      seq = next_id;
        else if (pick < 80) seq = next_id + ID_W'($urandom_range(1, 4));
        else if (pick < 86) seq = next_id + ID_W'($urandom_range(5, 300));
        else if (pick < 94) seq = next_id - ID_W'($urandom_range(1, 8));
      end else if (r < 66) begin
        kind = KIND_GET;
      end else if (r < 83) begin
        kind = KIND_RELEASE;
        if (held_slots.size() > 0 && $urandom_range(0, 4) != 0) slot = held_slots.pop_front();
      end else if (r < 93) begin
        kind = KIND_TIMEOUT;
        now  = wall_secs;
        // Land near the deadline to hit both sides of the compare.
        if ($urandom_range(0, 2) == 0)
          now = arrival_secs + ID_W'(tmo_limit) + ID_W'($urandom_range(0, 4)) - 2'd2;
      end else if (r < 96) begin
        kind = KIND_CLEAR;
        now  = wall_secs;
      end else begin
        kind = KIND_SPARE_A + KIND_W'($urandom_range(0, 2));
      end
      issue_command(kind, seq, len, slot, now);
      if (k == pause_at) wait_replies_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    tmo_limit    = RESET_TIMEOUT;
    last_limit   = RESET_TIMEOUT;
    next_id      = FIRST_ID;
    arrival_secs = '0;
    q_head       = '0;
    q_count      = '0;
    free_every_slot();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_corners();
    test_nak_and_wrap();
    test_full_queue();

    run_mixed_traffic(70, -1);
    wait_replies_drained();
    write_timeout_limit('0);
    run_mixed_traffic(70, 35);
    wait_replies_drained();
    write_timeout_limit({TMO_W{1'b1}});
    run_mixed_traffic(60, -1);
    wait_replies_drained();
    write_timeout_limit(TMO_W'($urandom_range(1, 254)));
    // Final stretch runs at full rate on both sides.
    gaps_on = 1'b0;
    run_mixed_traffic(55, -1);

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d replies: %0d NAKs, %0d refused stores.",
             items_sent, replies_seen, naks_seen, refusals_seen);
    $display("Timeout limits exercised: 20, 0, 255 and %0d seconds.", last_limit);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
